// ----- rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg - shared types and constants for the address-resolution cache
// field widths, operation codes and the control/status structs that join
// the controller and the datapath
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned IP_W      = 32;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned DEV_W     = 3;
  localparam int unsigned VER_W     = 32;
  // wide enough to compare a device index against a device count up to 511
  localparam int unsigned DEV_CMP_W = 9;

  // operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch the request and restart the scan
    logic scan;    // issue one key read and advance the scan pointer
    logic commit;  // write back and load the result register
  } arpc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;      // scan found a match or ran past the last filled slot
    logic out_free;  // result register can take a new beat this cycle
  } arpc_sts_t;

endpackage

// ----- rtl/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl - request sequencer
// accepts a request, runs the slot scan and commits the result
// ----------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  arpc_sts_t sts_i,
  output arpc_cmd_t cmd_o
);

  localparam logic IDLE_S = 1'b0;
  localparam logic SCAN_S = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      IDLE_S: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SCAN_S;
        end
      end
      SCAN_S: begin
        if (!sts_i.done) begin
          cmd_o.scan = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = IDLE_S;
        end
      end
      default: begin
        state_d = IDLE_S;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE_S;
    end else begin
      state_q <= state_d;
    end
  end

  // a commit always needs a finished scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.done)
    else $error("commit without finished scan");

  // after a commit the block is ready again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !in_stall_o)
    else $error("not ready after commit");

  // an accepted request blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o)
    else $error("ready while a request is in progress");

endmodule

// ----- rtl/arpc_dpath.sv -----
// ----------------------------------------------------------------------------
// arpc_dpath - table storage, scan pointer and result register
// key, mac and device memories with one registered read port
// ----------------------------------------------------------------------------
module arpc_dpath import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned DEVICES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arpc_cmd_t        cmd_i,
  output arpc_sts_t        sts_o,
  input  logic             func_i,
  input  logic [IP_W-1:0]  ip_address_i,
  input  logic [MAC_W-1:0] mac_in_i,
  input  logic [DEV_W-1:0] device_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             success_o,
  output logic [MAC_W-1:0] mac_out_o,
  output logic [DEV_W-1:0] device_out_o,
  output logic [VER_W-1:0] table_version_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(ENTRIES);
  localparam logic [DEV_CMP_W-1:0] DEV_LIM  = DEV_CMP_W'(DEVICES);

  // storage
  logic [IP_W-1:0]  key_mem [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];
  logic [DEV_W-1:0] dev_mem [ENTRIES];

  // request
  logic             req_func_q;
  logic [IP_W-1:0]  req_ip_q;
  logic [MAC_W-1:0] req_mac_q;
  logic [DEV_W-1:0] req_dev_q;

  // scan
  logic [CNT_W-1:0] fill_q, rd_idx_q;
  logic [IDX_W-1:0] cmp_idx_q, wr_slot;
  logic             cmp_vld_q;
  logic [IP_W-1:0]  key_rd_q;
  logic [MAC_W-1:0] mac_rd_q;
  logic [DEV_W-1:0] dev_rd_q;

  logic [VER_W-1:0] version_q, version_d;

  // result register
  logic             out_valid_q;
  logic             success_q;
  logic [MAC_W-1:0] mac_out_q;
  logic [DEV_W-1:0] dev_out_q;
  logic [VER_W-1:0] ver_out_q;

  logic match, is_upd, dev_ok, room, store, wr_en;

  assign match  = cmp_vld_q && (key_rd_q == req_ip_q);
  assign is_upd = (req_func_q == FUNC_UPDATE);
  assign dev_ok = ({{(DEV_CMP_W - DEV_W){1'b0}}, req_dev_q} < DEV_LIM);
  assign room   = (fill_q < FULL_CNT);
  assign store  = is_upd && dev_ok && (match || room);
  assign wr_en  = cmd_i.commit && store;
  assign wr_slot = match ? cmp_idx_q : fill_q[IDX_W-1:0];
  assign version_d = wr_en ? (version_q + VER_W'(1)) : version_q;

  assign sts_o.done     = match || (rd_idx_q == fill_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_func_q <= func_i;
      req_ip_q   <= ip_address_i;
      req_mac_q  <= mac_in_i;
      req_dev_q  <= device_in_i;
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_slot] <= req_ip_q;
      mac_mem[wr_slot] <= req_mac_q;
      dev_mem[wr_slot] <= req_dev_q;
    end
  end

  // memory read port, one slot per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      key_rd_q  <= key_mem[rd_idx_q[IDX_W-1:0]];
      mac_rd_q  <= mac_mem[rd_idx_q[IDX_W-1:0]];
      dev_rd_q  <= dev_mem[rd_idx_q[IDX_W-1:0]];
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      fill_q    <= '0;
      version_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_idx_q  <= rd_idx_q + CNT_W'(1);
        cmp_vld_q <= 1'b1;
      end
      if (wr_en && !match) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      version_q <= version_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      success_q <= is_upd ? store : match;
      mac_out_q <= (!is_upd && match) ? mac_rd_q : '0;
      dev_out_q <= (!is_upd && match) ? dev_rd_q : '0;
      ver_out_q <= version_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign success_o       = success_q;
  assign mac_out_o       = mac_out_q;
  assign device_out_o    = dev_out_q;
  assign table_version_o = ver_out_q;

  // the scan never runs past the filled slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_idx_q <= fill_q) && (fill_q <= FULL_CNT))
    else $error("scan pointer or fill count out of range");

  // a commit never overwrites a result beat still waiting on a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("pending result beat overwritten");

  // the version moves by one only on a stored update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> (version_q == $past(version_q)))
    else $error("version changed without a stored update");

endmodule

// ----- rtl/arp_cache_table.sv -----
// ----------------------------------------------------------------------------
// arp_cache_table - address-resolution cache
// maps an ipv4 address to a mac address and device index by linear search
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o): one beat per request, func_i
//   selects lookup or update; a beat is taken only while no request is in
//   flight, even if the previous result beat still waits on the output
//   output channel (out_valid_o / out_stall_i): exactly one result beat per
//   request, held in a result register until the receiver takes it
// scan
//   the scan reads one stored key per cycle through the memory read port;
//   the result beat is committed once a match is found or every filled slot
//   has been read, provided the result register is free; the next request
//   beat is taken in the cycle after the commit, so a new request is never
//   accepted while the previous one is still being scanned
// reset
//   fill count, version counter and all control state clear; table memories
//   are not cleared, slots at or above the fill count are never read
// stall
//   a finished request waits in the scan state while a result beat is still
//   stalled; input stays stalled until the result register frees up
// ----------------------------------------------------------------------------
module arp_cache_table import arpc_pkg::*; #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned DEVICES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             func_i,
  input  logic [IP_W-1:0]  ip_address_i,
  input  logic [MAC_W-1:0] mac_in_i,
  input  logic [DEV_W-1:0] device_in_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             success_o,
  output logic [MAC_W-1:0] mac_out_o,
  output logic [DEV_W-1:0] device_out_o,
  output logic [VER_W-1:0] table_version_o
);

  // command and status between sequencer and datapath
  arpc_cmd_t cmd;
  arpc_sts_t sts;

  // sequencer: idle -> scan -> commit
  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, scan pointer, version counter and result register
  arpc_dpath #(
    .ENTRIES (ENTRIES),
    .DEVICES (DEVICES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (func_i),
    .ip_address_i    (ip_address_i),
    .mac_in_i        (mac_in_i),
    .device_in_i     (device_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .success_o       (success_o),
    .mac_out_o       (mac_out_o),
    .device_out_o    (device_out_o),
    .table_version_o (table_version_o)
  );

endmodule
